// File: rtl/pbkdf_pkg.sv
// Shared types, constants and SHA-256 helper functions for the PBKDF2 engine.
package pbkdf_pkg;

  localparam int unsigned MIN_ITERATIONS = 1000;
  localparam int unsigned MAX_PASSWORD_BYTES = 128;
  localparam int unsigned MAX_SALT_BYTES = 120;
  localparam int unsigned MAX_KEY_BYTES = 128;

  localparam logic [1:0] ACT_LOAD_PASSWORD = 2'd0;
  localparam logic [1:0] ACT_LOAD_SALT = 2'd1;
  localparam logic [1:0] ACT_DERIVE = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam logic [1:0] REG_PASSWORD_LENGTH = 2'd0;
  localparam logic [1:0] REG_SALT_LENGTH = 2'd1;
  localparam logic [1:0] REG_ITERATION_COUNT = 2'd2;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd3;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [63:0] key_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        status;
  } result_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    sha_k = k;
  endfunction

endpackage

// File: rtl/pbkdf_sha_core.sv
// SHA-256 compression unit, one round per cycle with a rolling message schedule.
module pbkdf_sha_core import pbkdf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] hin,
  input  logic [511:0] blk,
  output logic         done,
  output logic [255:0] hout
);

  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [255:0] hreg;
  logic [6:0] round;
  logic running;

  logic [31:0] s1, ch, t1, s0, maj, t2, wnew;

  always_comb begin
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + sha_k(round[5:0]) + w[0];
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + maj;
    wnew = (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10)) + w[9] +
           (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        round <= '0;
      end else if (running) begin
        if (round == 7'd64) begin
          running <= 1'b0;
          done <= 1'b1;
        end else begin
          round <= round + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hreg <= hin;
      for (int i = 0; i < 8; i++) v[i] <= hin[255 - 32*i -: 32];
      for (int i = 0; i < 16; i++) w[i] <= blk[511 - 32*i -: 32];
    end else if (running) begin
      if (round == 7'd64) begin
        for (int i = 0; i < 8; i++) hout[255 - 32*i -: 32] <= hreg[255 - 32*i -: 32] + v[i];
      end else begin
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wnew;
      end
    end
  end

endmodule

// File: rtl/pbkdf2_hmac_sha256_engine.sv
// PBKDF2-HMAC-SHA-256 engine: byte stores, sequencer and one shared SHA-256 round unit.
// Loads leave busy low, so a new item may follow at once.
// A derive holds busy high through key setup and then each key block; a block read from a
// store is filled byte by byte before its compression. Each key block ends with its words
// one per cycle. A rejected derive's single result is set from state S_REJ;
// results are never stalled. Sync reset returns control, fills and registers to defaults.
module pbkdf2_hmac_sha256_engine import pbkdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output result_t     result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REJ  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_GO   = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [2:0] PH_PWH  = 3'd0;
  localparam logic [2:0] PH_KEYI = 3'd1;
  localparam logic [2:0] PH_KEYO = 3'd2;
  localparam logic [2:0] PH_SALT = 3'd3;
  localparam logic [2:0] PH_INU  = 3'd4;
  localparam logic [2:0] PH_OUT  = 3'd5;

  localparam logic [1:0] F_PWH  = 2'd0;
  localparam logic [1:0] F_KEY  = 2'd1;
  localparam logic [1:0] F_SALT = 2'd2;

  logic [7:0]  password_length;
  logic [6:0]  salt_length;
  logic [31:0] iteration_count;
  logic [7:0]  key_length;

  logic [7:0] password_store [MAX_PASSWORD_BYTES];
  logic [7:0] salt_store [MAX_SALT_BYTES];
  logic [7:0] password_fill;
  logic [6:0] salt_fill;
  logic [7:0] pw_rd, salt_rd;

  logic [2:0] state, phase;
  logic [1:0] fmode;
  logic [255:0] hstate, inner_midstate, outer_midstate, running_f;
  logic [511:0] blk_buf;
  logic [31:0] iteration_counter;
  logic [2:0] block_counter;
  logic [3:0] word_index;
  logic [1:0] blk_idx, last_blk;
  logic [7:0] msg_len;
  logic [10:0] msg_bits;
  logic [6:0] fill_pos;
  logic [5:0] pos_d;
  logic [7:0] m_d;
  logic valid_d;

  logic core_start, core_done;
  logic [255:0] core_hout;

  logic accept, derive, reject;
  logic [7:0] m_addr, fbyte, rem_bytes, salt_end;
  logic [8:0] bidx, salt_blocks, pw_blocks;
  logic [3:0] valid_n, nwords;
  logic [63:0] word_raw, word_mask;
  logic [255:0] f_next;
  logic [511:0] digest_blk;

  pbkdf_sha_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .hin(hstate), .blk(blk_buf),
    .done(core_done), .hout(core_hout)
  );

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign derive = accept && (item.action == ACT_DERIVE);
  assign core_start = (state == S_GO);
  assign reject = (password_length == 8'd0) ||
                  (32'(password_length) > MAX_PASSWORD_BYTES) ||
                  (salt_length == 7'd0) || (32'(salt_length) > MAX_SALT_BYTES) ||
                  (iteration_count < MIN_ITERATIONS) || (key_length == 8'd0) ||
                  (32'(key_length) > MAX_KEY_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      password_length <= 8'd0;
      salt_length <= 7'd0;
      iteration_count <= 32'd1000;
      key_length <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PASSWORD_LENGTH: password_length <= cfg_data[7:0];
        REG_SALT_LENGTH:     salt_length <= cfg_data[6:0];
        REG_ITERATION_COUNT: iteration_count <= cfg_data;
        REG_KEY_LENGTH:      key_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // byte stores
  assign m_addr = {blk_idx, fill_pos[5:0]};

  always_ff @(posedge clk) begin
    if (accept && item.action == ACT_LOAD_PASSWORD && 32'(password_fill) < MAX_PASSWORD_BYTES)
      password_store[password_fill[6:0]] <= item.byte_value;
    if (accept && item.action == ACT_LOAD_SALT && 32'(salt_fill) < MAX_SALT_BYTES)
      salt_store[salt_fill] <= item.byte_value;
    pw_rd <= password_store[m_addr[6:0]];
    salt_rd <= salt_store[(m_addr[6:0] < 7'(MAX_SALT_BYTES)) ? m_addr[6:0] : 7'd0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      password_fill <= '0;
      salt_fill <= '0;
    end else if (derive) begin
      password_fill <= '0;
      salt_fill <= '0;
    end else if (accept && item.action == ACT_LOAD_PASSWORD &&
                 32'(password_fill) < MAX_PASSWORD_BYTES) begin
      password_fill <= password_fill + 8'd1;
    end else if (accept && item.action == ACT_LOAD_SALT &&
                 32'(salt_fill) < MAX_SALT_BYTES) begin
      salt_fill <= salt_fill + 7'd1;
    end
  end

  // byte of the padded message, or of the ipad-masked key, at stream position m_d
  assign salt_end = {1'b0, salt_length} + 8'd3;
  always_comb begin
    fbyte = 8'h00;
    case (fmode)
      F_KEY: fbyte = ((m_d < password_length) ? pw_rd : 8'h00) ^ 8'h36;
      F_PWH: begin
        if (m_d < password_length) fbyte = pw_rd;
        else if (m_d == msg_len) fbyte = 8'h80;
      end
      F_SALT: begin
        if (m_d < {1'b0, salt_length}) fbyte = salt_rd;
        else if (m_d == salt_end) fbyte = {5'd0, block_counter};
        else if (m_d == msg_len) fbyte = 8'h80;
      end
      default: fbyte = 8'h00;
    endcase
    if (fmode != F_KEY && blk_idx == last_blk) begin
      if (pos_d == 6'd62) fbyte = {5'd0, msg_bits[10:8]};
      else if (pos_d == 6'd63) fbyte = msg_bits[7:0];
    end
  end

  assign bidx = 9'd511 - {pos_d, 3'b000};
  assign salt_blocks = 9'(salt_length) + 9'd76;
  assign pw_blocks = 9'(password_length) + 9'd72;
  assign digest_blk = {core_hout, 32'h80000000, 192'd0, 32'h00000300};
  assign f_next = (iteration_counter == 32'd1) ? core_hout : (running_f ^ core_hout);

  assign nwords = 4'(({1'b0, key_length} + 9'd7) >> 3);
  assign rem_bytes = key_length - {1'b0, word_index, 3'b000};
  assign valid_n = (rem_bytes > 8'd8) ? 4'd8 : rem_bytes[3:0];
  assign word_raw = running_f[255 - {word_index[1:0], 6'd0} -: 64];
  assign word_mask = ~(64'hffff_ffff_ffff_ffff >> {valid_n, 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_PWH;
      valid_d <= 1'b0;
      fill_pos <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (derive) begin
            if (reject) begin
              state <= S_REJ;
            end else begin
              state <= S_FILL;
              blk_idx <= 2'd0;
              fill_pos <= '0;
              valid_d <= 1'b0;
              hstate <= SHA_IV;
              msg_len <= password_length;
              msg_bits <= {password_length, 3'b000};
              last_blk <= pw_blocks[7:6] - 2'd1;
              if (password_length > 8'd64) begin
                phase <= PH_PWH;
                fmode <= F_PWH;
              end else begin
                phase <= PH_KEYI;
                fmode <= F_KEY;
              end
            end
          end
        end
        S_REJ: begin
          result_valid <= 1'b1;
          result <= '{key_word: 64'd0, valid_bytes: 4'd0, last_word: 1'b1, status: 1'b1};
          state <= S_IDLE;
        end
        S_FILL: begin
          if (!fill_pos[6]) fill_pos <= fill_pos + 7'd1;
          valid_d <= !fill_pos[6];
          pos_d <= fill_pos[5:0];
          m_d <= m_addr;
          if (valid_d) begin
            blk_buf[bidx -: 8] <= fbyte;
            if (pos_d == 6'd63) state <= S_GO;
          end
        end
        S_GO: state <= S_RUN;
        S_RUN: begin
          if (core_done) begin
            case (phase)
              PH_PWH: begin
                if (blk_idx != last_blk) begin
                  hstate <= core_hout;
                  blk_idx <= blk_idx + 2'd1;
                  fill_pos <= '0;
                  valid_d <= 1'b0;
                  state <= S_FILL;
                end else begin
                  blk_buf <= {core_hout, 256'd0} ^ {64{8'h36}};
                  hstate <= SHA_IV;
                  phase <= PH_KEYI;
                  state <= S_GO;
                end
              end
              PH_KEYI: begin
                inner_midstate <= core_hout;
                blk_buf <= blk_buf ^ {64{8'h6a}};
                hstate <= SHA_IV;
                phase <= PH_KEYO;
                state <= S_GO;
              end
              PH_KEYO: begin
                outer_midstate <= core_hout;
                hstate <= inner_midstate;
                block_counter <= 3'd1;
                word_index <= 4'd0;
                iteration_counter <= 32'd1;
                fmode <= F_SALT;
                phase <= PH_SALT;
                blk_idx <= 2'd0;
                fill_pos <= '0;
                valid_d <= 1'b0;
                msg_len <= {1'b0, salt_length} + 8'd4;
                msg_bits <= {{1'b0, salt_length} + 8'd68, 3'b000};
                last_blk <= salt_blocks[7:6] - 2'd1;
                state <= S_FILL;
              end
              PH_SALT: begin
                if (blk_idx != last_blk) begin
                  hstate <= core_hout;
                  blk_idx <= blk_idx + 2'd1;
                  fill_pos <= '0;
                  valid_d <= 1'b0;
                  state <= S_FILL;
                end else begin
                  blk_buf <= digest_blk;
                  hstate <= outer_midstate;
                  phase <= PH_OUT;
                  state <= S_GO;
                end
              end
              PH_INU: begin
                blk_buf <= digest_blk;
                hstate <= outer_midstate;
                phase <= PH_OUT;
                state <= S_GO;
              end
              default: begin
                running_f <= f_next;
                if (iteration_counter < iteration_count) begin
                  iteration_counter <= iteration_counter + 32'd1;
                  blk_buf <= digest_blk;
                  hstate <= inner_midstate;
                  phase <= PH_INU;
                  state <= S_GO;
                end else begin
                  state <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          result <= '{key_word: word_raw & word_mask, valid_bytes: valid_n,
                      last_word: (word_index + 4'd1 == nwords), status: 1'b0};
          word_index <= word_index + 4'd1;
          if (word_index + 4'd1 == nwords) begin
            state <= S_IDLE;
          end else if (word_index[1:0] == 2'd3) begin
            block_counter <= block_counter + 3'd1;
            hstate <= inner_midstate;
            iteration_counter <= 32'd1;
            phase <= PH_SALT;
            blk_idx <= 2'd0;
            fill_pos <= '0;
            valid_d <= 1'b0;
            state <= S_FILL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/pbkdf_checker.sv
// Port-level checker for the PBKDF2 engine, bound to the top level.
module pbkdf_checker import pbkdf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    result_valid,
  input result_t result
);

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy || $past(busy)) else $error("result outside a derive");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> result.last_word && result.valid_bytes == 4'd0)
    else $error("rejection not a lone final beat");

  a_data_bytes: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.status |-> result.valid_bytes != 4'd0 &&
    result.valid_bytes <= 4'd8) else $error("bad byte count");

  a_derive_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.action == ACT_DERIVE |=> busy) else $error("derive not taken");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid) else $error("not idle after reset");

endmodule

bind pbkdf2_hmac_sha256_engine pbkdf_checker u_pbkdf_checker (
  .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
  .result_valid(result_valid), .result(result)
);

// File: bench/tb_top.sv
// Self-checking bench for the PBKDF2-HMAC-SHA-256 engine with a built-in key predictor.
module tb_top;
  import pbkdf_pkg::*;

  class key_scoreboard;
    bit [7:0]  pw_mem[128];
    bit [7:0]  salt_mem[120];
    int        pw_fill, salt_fill;
    bit [7:0]  pw_len;
    bit [6:0]  salt_bytes;
    bit [31:0] iters;
    bit [7:0]  key_len;
    bit [31:0] inner[8], outer[8];
    bit [31:0] kt[64];
    result_t   pending[$];
    int        errors, words_seen, rejects_seen, derives_ok;

    function new();
      kt = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      pw_len = 0; salt_bytes = 0; iters = 1000; key_len = 32;
    endfunction

    function bit [31:0] rr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress(inout bit [31:0] st[8], input bit [7:0] blk[64]);
      bit [31:0] w[64];
      bit [31:0] v[8];
      bit [31:0] t1, t2;
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++)
        w[t] = (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
               (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      v = st;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + kt[t] + w[t];
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) st[i] += v[i];
    endfunction

    function void digest(input bit [31:0] init[8], input int prefix, input bit [7:0] m[],
                         input int len, output bit [31:0] st[8]);
      bit [7:0] tail[128];
      bit [7:0] blk[64];
      int full, rem, total;
      bit [63:0] bits;
      st = init;
      full = len / 64;
      for (int i = 0; i < full; i++) begin
        for (int j = 0; j < 64; j++) blk[j] = m[64*i + j];
        compress(st, blk);
      end
      rem = len - 64 * full;
      for (int j = 0; j < 128; j++) tail[j] = 0;
      for (int j = 0; j < rem; j++) tail[j] = m[64*full + j];
      tail[rem] = 8'h80;
      total = (rem + 9 <= 64) ? 64 : 128;
      bits = 64'(prefix + len) * 8;
      for (int i = 0; i < 8; i++) tail[total - 1 - i] = bits[8*i +: 8];
      for (int j = 0; j < 64; j++) blk[j] = tail[j];
      compress(st, blk);
      if (total == 128) begin
        for (int j = 0; j < 64; j++) blk[j] = tail[64 + j];
        compress(st, blk);
      end
    endfunction

    function void to_bytes(input bit [31:0] w[8], output bit [7:0] b[]);
      b = new[32];
      for (int i = 0; i < 32; i++) b[i] = 8'(w[i/4] >> (24 - 8 * (i % 4)));
    endfunction

    function void hmac(input bit [7:0] m[], input int len, output bit [31:0] u[8]);
      bit [31:0] tmp[8];
      bit [7:0] tb[];
      digest(inner, 64, m, len, tmp);
      to_bytes(tmp, tb);
      digest(outer, 64, tb, 32, u);
    endfunction

    function void write_reg(bit [1:0] idx, bit [31:0] data);
      case (idx)
        REG_PASSWORD_LENGTH: pw_len = data[7:0];
        REG_SALT_LENGTH:     salt_bytes = data[6:0];
        REG_ITERATION_COUNT: iters = data;
        REG_KEY_LENGTH:      key_len = data[7:0];
        default: ;
      endcase
    endfunction

    function void derive();
      bit [31:0] iv[8], d[8], u[8], f[8];
      bit [7:0] kb[64], pad[64], okey[128];
      bit [7:0] m[], ub[];
      int blocks, n;
      result_t r;
      pw_fill = 0; salt_fill = 0;
      if (pw_len == 0 || pw_len > MAX_PASSWORD_BYTES || salt_bytes == 0 ||
          salt_bytes > MAX_SALT_BYTES || iters < MIN_ITERATIONS || key_len == 0 ||
          key_len > MAX_KEY_BYTES) begin
        r = '{key_word: 64'd0, valid_bytes: 4'd0, last_word: 1'b1, status: 1'b1};
        pending.push_back(r);
        return;
      end
      derives_ok++;
      for (int i = 0; i < 8; i++) iv[i] = SHA_IV[255 - 32*i -: 32];
      for (int i = 0; i < 64; i++) kb[i] = 0;
      if (pw_len > 64) begin
        m = new[pw_len];
        for (int i = 0; i < pw_len; i++) m[i] = pw_mem[i];
        digest(iv, 0, m, pw_len, d);
        to_bytes(d, ub);
        for (int i = 0; i < 32; i++) kb[i] = ub[i];
      end else begin
        for (int i = 0; i < pw_len; i++) kb[i] = pw_mem[i];
      end
      inner = iv; outer = iv;
      for (int i = 0; i < 64; i++) pad[i] = kb[i] ^ 8'h36;
      compress(inner, pad);
      for (int i = 0; i < 64; i++) pad[i] = kb[i] ^ 8'h5c;
      compress(outer, pad);
      for (int i = 0; i < 128; i++) okey[i] = 0;
      blocks = (key_len + 31) / 32;
      for (int b = 1; b <= blocks; b++) begin
        m = new[salt_bytes + 4];
        for (int i = 0; i < salt_bytes; i++) m[i] = salt_mem[i];
        m[salt_bytes] = 8'd0; m[salt_bytes+1] = 8'd0; m[salt_bytes+2] = 8'd0;
        m[salt_bytes+3] = 8'(b);
        hmac(m, salt_bytes + 4, u);
        f = u;
        for (longint it = 1; it < iters; it++) begin
          to_bytes(u, ub);
          hmac(ub, 32, u);
          for (int i = 0; i < 8; i++) f[i] ^= u[i];
        end
        to_bytes(f, ub);
        n = key_len - 32 * (b - 1);
        if (n > 32) n = 32;
        for (int i = 0; i < n; i++) okey[32*(b-1) + i] = ub[i];
      end
      n = (key_len + 7) / 8;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < 8; j++) r.key_word[63 - 8*j -: 8] = okey[8*i + j];
        r.valid_bytes = (key_len - 8*i > 8) ? 4'd8 : 4'(key_len - 8*i);
        r.last_word = (i + 1 == n);
        r.status = 1'b0;
        pending.push_back(r);
      end
    endfunction

    function void note(item_t it);
      case (it.action)
        ACT_LOAD_PASSWORD: if (pw_fill < MAX_PASSWORD_BYTES) pw_mem[pw_fill++] = it.byte_value;
        ACT_LOAD_SALT:     if (salt_fill < MAX_SALT_BYTES) salt_mem[salt_fill++] = it.byte_value;
        ACT_DERIVE:        derive();
        default: ;
      endcase
    endfunction

    function void check(result_t got);
      result_t want;
      if (got.status) rejects_seen++; else words_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("beat mismatch: key %h/%h valid %0d/%0d last %b/%b status %b/%b",
                   want.key_word, got.key_word, want.valid_bytes, got.valid_bytes,
                   want.last_word, got.last_word, want.status, got.status);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  item_t       item = '0;
  logic        busy;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        result_valid;
  result_t     result;

  key_scoreboard sb = new();
  int idle_pct = 0;

  pbkdf2_hmac_sha256_engine DUT (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check(result);
  end

  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send(bit [1:0] act, bit [7:0] val);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start = 1;
    item = '{action: act, byte_value: val};
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(item);
    @(negedge clk);
  endtask

  task automatic settle();
    start = 0;
    while (sb.pending.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [31:0] data);
    cfg_valid = 1; cfg_index = idx; cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_all(bit [31:0] pl, bit [31:0] sl, bit [31:0] it, bit [31:0] kl);
    settle();
    write_reg(REG_PASSWORD_LENGTH, pl);
    write_reg(REG_SALT_LENGTH, sl);
    write_reg(REG_ITERATION_COUNT, it);
    write_reg(REG_KEY_LENGTH, kl);
  endtask

  task automatic derive_with(int pl, int sl, bit [31:0] it, int kl, int npw, int nsalt);
    set_all(pl, sl, it, kl);
    for (int i = 0; i < npw; i++) send(ACT_LOAD_PASSWORD, 8'($urandom_range(255)));
    for (int i = 0; i < nsalt; i++) send(ACT_LOAD_SALT, 8'($urandom_range(255)));
    send(ACT_DERIVE, 8'($urandom_range(255)));
    settle();
  endtask

  task automatic bad_config();
    bit [31:0] pl, sl, it, kl;
    pl = $urandom_range(255); sl = $urandom_range(127);
    it = $urandom; kl = $urandom_range(255);
    case ($urandom_range(3))
      0: pl = ($urandom_range(1)) ? 0 : $urandom_range(129, 255);
      1: sl = ($urandom_range(1)) ? 0 : $urandom_range(121, 127);
      2: it = $urandom_range(999);
      default: kl = ($urandom_range(1)) ? 0 : $urandom_range(129, 255);
    endcase
    set_all(pl, sl, it, kl);
  endtask

  initial begin
    int phase_idle[4] = '{0, 55, 0, 36};
    repeat (4) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // defaults reject (no password length); unknown action is ignored
    send(ACT_IGNORED, 8'hff);
    send(ACT_DERIVE, 8'h00);
    settle();
    // smallest key, extreme byte values
    set_all(1, 1, 1000, 1);
    send(ACT_LOAD_PASSWORD, 8'h00);
    send(ACT_LOAD_SALT, 8'hff);
    send(ACT_DERIVE, 8'hff);
    settle();
    // parameter rejects at each boundary
    set_all(5, 0, 1000, 32);          send(ACT_DERIVE, 0); settle();
    set_all(5, 121, 1000, 32);        send(ACT_DERIVE, 0); settle();
    set_all(5, 127, 1000, 32);        send(ACT_DERIVE, 0); settle();
    set_all(5, 5, 999, 32);           send(ACT_DERIVE, 0); settle();
    set_all(5, 5, 32'hffffffff, 0);   send(ACT_DERIVE, 0); settle();
    set_all(129, 5, 1000, 129);       send(ACT_DERIVE, 0); settle();
    set_all(255, 5, 1000, 255);       send(ACT_DERIVE, 0); settle();
    // hashed password just over one block, two-block inner hash, longest key
    derive_with(65, 52, 1000, 128, 65, 52);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      bad_config();
      for (int n = 0; n < 6; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: send(ACT_LOAD_PASSWORD, 8'($urandom_range(255)));
          4, 5, 6:    send(ACT_LOAD_SALT, 8'($urandom_range(255)));
          7:          send(ACT_IGNORED, 8'($urandom_range(255)));
          default:    send(ACT_DERIVE, 8'($urandom_range(255)));
        endcase
      end
      settle();
    end
    // one random well-formed derive over store bytes written above
    idle_pct = 36;
    derive_with($urandom_range(1, 65), $urandom_range(1, 52), $urandom_range(1000, 1003),
                $urandom_range(1, 32), $urandom_range(0, 3), $urandom_range(0, 3));
    settle();

    $display("Covered %0d accepted derivations (%0d key beats) and %0d rejected ones.",
             sb.derives_ok, sb.words_seen, sb.rejects_seen);
    $display("Loads, ignored actions, rejected parameter sets and sender gaps were mixed in.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/pbkdf_pkg.sv
rtl/pbkdf_sha_core.sv
rtl/pbkdf2_hmac_sha256_engine.sv
rtl/pbkdf_checker.sv
bench/tb_top.sv
